[rtl/tdo_pkg.sv]
// Shared types and constants for the target distance objective block.
// Used by tdo_cfg, tdo_mul, tdo_div and target_distance_objective; no dependencies.
package tdo_pkg;

    // Vector length limit and the element counter sized to hold it
    localparam int MAX_ELEMENTS = 64;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

    // Field and datapath widths
    localparam int DATA_W  = 16;
    localparam int ACC_W   = 48;
    localparam int SPR_W   = 24;
    localparam int MUL_W   = 18;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int G_W     = 36;
    localparam int GRAD_W  = 32;
    localparam int OBJ_W   = 48;
    localparam int MAG_W   = 58;
    localparam int NUM_W   = 41;
    localparam int STEP_W  = $clog2(NUM_W);

    // Configuration port
    localparam int ADDR_W    = 5;
    localparam int APB_W     = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_DISTANCE_WEIGHT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BOUND_WEIGHT    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SPREAD_WEIGHT   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BOUNDS_ENABLE   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SPREAD_ENABLE   = 3'd4;

    // Register values seen by the datapath
    typedef struct packed {
        logic [DATA_W-1:0] distance_weight;
        logic [DATA_W-1:0] bound_weight;
        logic [DATA_W-1:0] spread_weight;
        logic              bounds_enable;
        logic              spread_enable;
    } cfg_t;

    // What a product is for, carried alongside it through the multiplier
    typedef enum logic [3:0] {
        TAG_NONE   = 4'd0,
        TAG_DIST   = 4'd1,
        TAG_VIOL   = 4'd2,
        TAG_GRAD_D = 4'd3,
        TAG_GRAD_L = 4'd4,
        TAG_GRAD_U = 4'd5,
        TAG_OBJ0   = 4'd6,
        TAG_OBJ1   = 4'd7,
        TAG_OBJ2   = 4'd8,
        TAG_SPR0   = 4'd9,
        TAG_SPR1   = 4'd10
    } tag_t;

    typedef struct packed {
        tag_t                     tag;
        logic signed [MUL_W-1:0]  a;
        logic signed [MUL_W-1:0]  b;
    } mul_req_t;

    typedef struct packed {
        tag_t                     tag;
        logic signed [PROD_W-1:0] prod;
    } mul_rsp_t;

endpackage

[rtl/tdo_cfg.sv]
// APB register file for the target distance objective block.
// Depends on tdo_pkg for the register indexes and the cfg_t bundle.
module tdo_cfg
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tdo_pkg::ADDR_W-1:0] paddr,
    input  logic [tdo_pkg::APB_W-1:0]  pwdata,
    output logic [tdo_pkg::APB_W-1:0]  prdata,
    output logic                       pready,
    output tdo_pkg::cfg_t              cfg
);

    tdo_pkg::cfg_t                    cfg_reg;
    logic [tdo_pkg::REG_IDX_W-1:0]    idx;
    logic                             wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[tdo_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Write the addressed register at the end of the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.distance_weight <= 16'd256;
            cfg_reg.bound_weight    <= 16'd256;
            cfg_reg.spread_weight   <= 16'd0;
            cfg_reg.bounds_enable   <= 1'b0;
            cfg_reg.spread_enable   <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                tdo_pkg::REG_DISTANCE_WEIGHT:
                    cfg_reg.distance_weight <= pwdata[tdo_pkg::DATA_W-1:0];
                tdo_pkg::REG_BOUND_WEIGHT:
                    cfg_reg.bound_weight <= pwdata[tdo_pkg::DATA_W-1:0];
                tdo_pkg::REG_SPREAD_WEIGHT:
                    cfg_reg.spread_weight <= pwdata[tdo_pkg::DATA_W-1:0];
                tdo_pkg::REG_BOUNDS_ENABLE:
                    cfg_reg.bounds_enable <= pwdata[0];
                tdo_pkg::REG_SPREAD_ENABLE:
                    cfg_reg.spread_enable <= pwdata[0];
                default:
                    ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        prdata = '0;
        unique case (idx)
            tdo_pkg::REG_DISTANCE_WEIGHT:
                prdata = tdo_pkg::APB_W'(cfg_reg.distance_weight);
            tdo_pkg::REG_BOUND_WEIGHT:
                prdata = tdo_pkg::APB_W'(cfg_reg.bound_weight);
            tdo_pkg::REG_SPREAD_WEIGHT:
                prdata = tdo_pkg::APB_W'(cfg_reg.spread_weight);
            tdo_pkg::REG_BOUNDS_ENABLE:
                prdata = tdo_pkg::APB_W'(cfg_reg.bounds_enable);
            tdo_pkg::REG_SPREAD_ENABLE:
                prdata = tdo_pkg::APB_W'(cfg_reg.spread_enable);
            default:
                prdata = '0;
        endcase
    end

endmodule

[rtl/tdo_mul.sv]
// Shared signed 18x18 multiplier with a registered product and tag.
// Depends on tdo_pkg for the request and response structs.
module tdo_mul
(
    input  logic              clk,
    input  logic              rst_n,
    input  tdo_pkg::mul_req_t req,
    output tdo_pkg::mul_rsp_t rsp
);

    tdo_pkg::tag_t                     tag_reg;
    logic signed [tdo_pkg::PROD_W-1:0] prod_reg;

    // Carry the tag so the consumer knows what the product is for
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= tdo_pkg::TAG_NONE;
        end
        else
        begin
            tag_reg <= req.tag;
        end
    end

    // Register the product
    always_ff @(posedge clk)
    begin
        prod_reg <= req.a * req.b;
    end

    assign rsp.tag  = tag_reg;
    assign rsp.prod = prod_reg;

endmodule

[rtl/tdo_div.sv]
// Restoring divider, one quotient bit per cycle, for the mean uncertainty term.
// Depends on tdo_pkg for the dividend and divisor widths.
module tdo_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [tdo_pkg::NUM_W-1:0] num,
    input  logic [tdo_pkg::CNT_W-1:0] den,
    output logic                      done,
    output logic [tdo_pkg::NUM_W-1:0] quot
);

    logic                       busy_reg;
    logic                       done_reg;
    logic [tdo_pkg::STEP_W-1:0] step_reg;
    logic [tdo_pkg::CNT_W-1:0]  rem_reg;
    logic [tdo_pkg::NUM_W-1:0]  quo_reg;
    logic [tdo_pkg::CNT_W-1:0]  den_reg;
    logic [tdo_pkg::CNT_W:0]    trial;
    logic [tdo_pkg::CNT_W:0]    diff;
    logic                       ge;

    // Shift in the next dividend bit and try a subtract
    always_comb
    begin
        trial = {rem_reg, quo_reg[tdo_pkg::NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});
    end

    // Step counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == tdo_pkg::STEP_W'(tdo_pkg::NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[tdo_pkg::CNT_W-1:0] : trial[tdo_pkg::CNT_W-1:0];
            quo_reg <= {quo_reg[tdo_pkg::NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

[rtl/target_distance_objective.sv]
// Target distance objective: per-element gradient and per-vector objective value.
// Depends on tdo_pkg, tdo_cfg, tdo_mul and tdo_div.
//
// One vector element enters per input transfer and yields exactly one result
// transfer carrying its gradient; the element marked with s_tlast also carries
// the objective value and flags it on m_tuser. All products come from a single
// 18x18 multiplier issuing one product per cycle under a small sequencer; an
// ordinary element goes through 6 multiplier slots, a drain state and the result
// load before the next element can be taken. The last element of a vector adds
// 8 more multiplier slots for the weighted sums and a bit-serial divider for
// the mean uncertainty. The result sits in an output register, so the next
// element is taken while a result still waits for m_tready. Registers are
// written over APB at byte address 4*i.
module target_distance_objective
(
    input  logic                       clk,
    input  logic                       rst_n,
    // Input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [79:0]                s_tdata,   // predicted, goal, lower_limit, upper_limit, spread
    input  logic [2:0]                 s_tuser,   // has_lower, has_upper, has_spread
    input  logic                       s_tlast,   // final_element
    // Result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [79:0]                m_tdata,   // grad, objective
    output logic [0:0]                 m_tuser,   // value_valid
    // Configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tdo_pkg::ADDR_W-1:0] paddr,
    input  logic [tdo_pkg::APB_W-1:0]  pwdata,
    output logic [tdo_pkg::APB_W-1:0]  prdata,
    output logic                       pready
);

    typedef enum logic [19:0] {
        ST_IDLE   = 20'h00001,
        ST_DD     = 20'h00002,
        ST_GD     = 20'h00004,
        ST_LV     = 20'h00008,
        ST_LG     = 20'h00010,
        ST_UV     = 20'h00020,
        ST_UG     = 20'h00040,
        ST_GW     = 20'h00080,
        ST_D0     = 20'h00100,
        ST_D1     = 20'h00200,
        ST_D2     = 20'h00400,
        ST_B0     = 20'h00800,
        ST_B1     = 20'h01000,
        ST_B2     = 20'h02000,
        ST_S0     = 20'h04000,
        ST_S1     = 20'h08000,
        ST_SW     = 20'h10000,
        ST_DSTART = 20'h20000,
        ST_DWAIT  = 20'h40000,
        ST_OUT    = 20'h80000
    } state_t;

    localparam int DW = tdo_pkg::DATA_W;

    tdo_pkg::cfg_t     cfg;
    tdo_pkg::mul_req_t mul_req;
    tdo_pkg::mul_rsp_t mul_rsp;

    state_t state_reg, state_next;

    // Control and vector state
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [tdo_pkg::ACC_W-1:0]   dist_acc_reg, dist_acc_next;
    logic [tdo_pkg::ACC_W-1:0]   viol_acc_reg, viol_acc_next;
    logic [tdo_pkg::SPR_W-1:0]   spread_acc_reg, spread_acc_next;
    logic [tdo_pkg::CNT_W-1:0]   elem_count_reg, elem_count_next;
    logic                        spread_seen_reg, spread_seen_next;

    // Element and working payload
    logic [DW-1:0]               pred_reg, pred_next;
    logic [DW-1:0]               goal_reg, goal_next;
    logic [DW-1:0]               lo_reg, lo_next;
    logic [DW-1:0]               hi_reg, hi_next;
    logic                        has_lo_reg, has_lo_next;
    logic                        has_hi_reg, has_hi_next;
    logic                        fin_reg, fin_next;
    logic [tdo_pkg::G_W-1:0]     g_reg, g_next;
    logic [tdo_pkg::MAG_W-1:0]   mag_reg, mag_next;
    logic [tdo_pkg::NUM_W-1:0]   num_reg, num_next;
    logic [tdo_pkg::GRAD_W-1:0]  grad_out_reg, grad_out_next;
    logic [tdo_pkg::OBJ_W-1:0]   obj_out_reg, obj_out_next;
    logic                        vv_out_reg, vv_out_next;

    // Derived values
    logic [DW:0]                 d_diff;
    logic [DW:0]                 lo_diff;
    logic [DW:0]                 hi_diff;
    logic [DW-1:0]               vl;
    logic [DW-1:0]               vu;
    logic [DW-1:0]               bw_eff;
    logic [tdo_pkg::GRAD_W-1:0]  grad_sat;
    logic [tdo_pkg::MAG_W-1:0]   mag_sat;
    logic [32:0]                 obj_rnd;
    logic [tdo_pkg::SPR_W:0]     spr_sum;
    logic                        spread_apply;
    logic                        out_free;
    logic                        div_start;
    logic                        div_done;
    logic [tdo_pkg::NUM_W-1:0]   div_quot;

    // Saturating add of a non-negative product into a 48-bit sum
    function automatic logic [tdo_pkg::ACC_W-1:0] acc_add(
        input logic [tdo_pkg::ACC_W-1:0] acc,
        input logic [31:0]               x
    );
        logic [tdo_pkg::ACC_W:0] s;
        s = {1'b0, acc} + (tdo_pkg::ACC_W + 1)'(x);
        return s[tdo_pkg::ACC_W] ? {tdo_pkg::ACC_W{1'b1}} : s[tdo_pkg::ACC_W-1:0];
    endfunction

    tdo_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tdo_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    tdo_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (elem_count_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Distance and bound violations of the held element
    always_comb
    begin
        d_diff  = {pred_reg[DW-1], pred_reg} - {goal_reg[DW-1], goal_reg};
        lo_diff = {lo_reg[DW-1], lo_reg} - {pred_reg[DW-1], pred_reg};
        hi_diff = {pred_reg[DW-1], pred_reg} - {hi_reg[DW-1], hi_reg};
        vl      = (has_lo_reg && !lo_diff[DW] && (lo_diff != '0)) ? lo_diff[DW-1:0] : '0;
        vu      = (has_hi_reg && !hi_diff[DW] && (hi_diff != '0)) ? hi_diff[DW-1:0] : '0;
        bw_eff  = cfg.bounds_enable ? cfg.bound_weight : '0;
    end

    // Clamp gradient to 32 bits and objective magnitude to 2^47
    always_comb
    begin
        if ((g_reg[tdo_pkg::G_W-1:tdo_pkg::GRAD_W-1] == '0) ||
            (g_reg[tdo_pkg::G_W-1:tdo_pkg::GRAD_W-1] == '1))
        begin
            grad_sat = g_reg[tdo_pkg::GRAD_W-1:0];
        end
        else
        begin
            grad_sat = g_reg[tdo_pkg::G_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        mag_sat = (mag_reg > tdo_pkg::MAG_W'(48'h8000_0000_0000)) ?
                  tdo_pkg::MAG_W'(48'h8000_0000_0000) : mag_reg;
    end

    assign spread_apply = cfg.spread_enable && spread_seen_reg && (elem_count_reg != '0);
    assign out_free     = !m_tvalid_reg || m_tready;
    assign obj_rnd      = {1'b0, mul_rsp.prod[31:0]} + 33'd128;
    assign spr_sum      = {1'b0, spread_acc_reg} + (tdo_pkg::SPR_W + 1)'(s_tdata[79:64]);

    // Sequencer, accumulation of returned products and result load
    always_comb
    begin
        state_next       = state_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        dist_acc_next    = dist_acc_reg;
        viol_acc_next    = viol_acc_reg;
        spread_acc_next  = spread_acc_reg;
        elem_count_next  = elem_count_reg;
        spread_seen_next = spread_seen_reg;
        pred_next        = pred_reg;
        goal_next        = goal_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        has_lo_next      = has_lo_reg;
        has_hi_next      = has_hi_reg;
        fin_next         = fin_reg;
        g_next           = g_reg;
        mag_next         = mag_reg;
        num_next         = num_reg;
        grad_out_next    = grad_out_reg;
        obj_out_next     = obj_out_reg;
        vv_out_next      = vv_out_reg;
        mul_req.tag      = tdo_pkg::TAG_NONE;
        mul_req.a        = '0;
        mul_req.b        = '0;
        div_start        = 1'b0;
        s_tready         = 1'b0;

        // Fold the product that leaves the multiplier this cycle
        case (mul_rsp.tag)
            tdo_pkg::TAG_DIST:
                dist_acc_next = acc_add(dist_acc_reg, mul_rsp.prod[31:0]);
            tdo_pkg::TAG_VIOL:
                viol_acc_next = acc_add(viol_acc_reg, mul_rsp.prod[31:0]);
            tdo_pkg::TAG_GRAD_D:
                g_next = tdo_pkg::G_W'(0) - {mul_rsp.prod[tdo_pkg::PROD_W-2:0], 1'b0};
            tdo_pkg::TAG_GRAD_L:
                if (cfg.bounds_enable)
                begin
                    g_next = g_reg + {mul_rsp.prod[tdo_pkg::PROD_W-2:0], 1'b0};
                end
            tdo_pkg::TAG_GRAD_U:
                if (cfg.bounds_enable)
                begin
                    g_next = g_reg - {mul_rsp.prod[tdo_pkg::PROD_W-2:0], 1'b0};
                end
            tdo_pkg::TAG_OBJ0:
                mag_next = mag_reg + tdo_pkg::MAG_W'(obj_rnd[32:8]);
            tdo_pkg::TAG_OBJ1:
                mag_next = mag_reg + tdo_pkg::MAG_W'({mul_rsp.prod[31:0], 8'b0});
            tdo_pkg::TAG_OBJ2:
                mag_next = mag_reg + tdo_pkg::MAG_W'({mul_rsp.prod[31:0], 24'b0});
            tdo_pkg::TAG_SPR0:
                num_next = tdo_pkg::NUM_W'(mul_rsp.prod[31:0]) +
                           tdo_pkg::NUM_W'(elem_count_reg >> 1);
            tdo_pkg::TAG_SPR1:
                num_next = num_reg + tdo_pkg::NUM_W'({mul_rsp.prod[23:0], 16'b0});
            default:
                ;
        endcase

        unique case (state_reg)
            ST_IDLE:
            begin
                // Take an element and update the per-vector counters
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    pred_next   = s_tdata[15:0];
                    goal_next   = s_tdata[31:16];
                    lo_next     = s_tdata[47:32];
                    hi_next     = s_tdata[63:48];
                    has_lo_next = s_tuser[0];
                    has_hi_next = s_tuser[1];
                    fin_next    = s_tlast;
                    mag_next    = '0;
                    if (s_tuser[2])
                    begin
                        spread_acc_next  = spr_sum[tdo_pkg::SPR_W] ?
                                           {tdo_pkg::SPR_W{1'b1}} :
                                           spr_sum[tdo_pkg::SPR_W-1:0];
                        spread_seen_next = 1'b1;
                    end
                    if (elem_count_reg < tdo_pkg::CNT_W'(tdo_pkg::MAX_ELEMENTS))
                    begin
                        elem_count_next = elem_count_reg + 1'b1;
                    end
                    state_next = ST_DD;
                end
            end
            ST_DD:
            begin
                mul_req.tag = tdo_pkg::TAG_DIST;
                mul_req.a   = {d_diff[DW], d_diff};
                mul_req.b   = {d_diff[DW], d_diff};
                state_next  = ST_GD;
            end
            ST_GD:
            begin
                mul_req.tag = tdo_pkg::TAG_GRAD_D;
                mul_req.a   = {2'b00, cfg.distance_weight};
                mul_req.b   = {d_diff[DW], d_diff};
                state_next  = ST_LV;
            end
            ST_LV:
            begin
                mul_req.tag = tdo_pkg::TAG_VIOL;
                mul_req.a   = {2'b00, vl};
                mul_req.b   = {2'b00, vl};
                state_next  = ST_LG;
            end
            ST_LG:
            begin
                mul_req.tag = tdo_pkg::TAG_GRAD_L;
                mul_req.a   = {2'b00, cfg.bound_weight};
                mul_req.b   = {2'b00, vl};
                state_next  = ST_UV;
            end
            ST_UV:
            begin
                mul_req.tag = tdo_pkg::TAG_VIOL;
                mul_req.a   = {2'b00, vu};
                mul_req.b   = {2'b00, vu};
                state_next  = ST_UG;
            end
            ST_UG:
            begin
                mul_req.tag = tdo_pkg::TAG_GRAD_U;
                mul_req.a   = {2'b00, cfg.bound_weight};
                mul_req.b   = {2'b00, vu};
                state_next  = fin_reg ? ST_D0 : ST_GW;
            end
            ST_GW:
            begin
                // Let the last gradient product land
                state_next = ST_OUT;
            end
            ST_D0:
            begin
                mul_req.tag = tdo_pkg::TAG_OBJ0;
                mul_req.a   = {2'b00, cfg.distance_weight};
                mul_req.b   = {2'b00, dist_acc_reg[15:0]};
                state_next  = ST_D1;
            end
            ST_D1:
            begin
                mul_req.tag = tdo_pkg::TAG_OBJ1;
                mul_req.a   = {2'b00, cfg.distance_weight};
                mul_req.b   = {2'b00, dist_acc_reg[31:16]};
                state_next  = ST_D2;
            end
            ST_D2:
            begin
                mul_req.tag = tdo_pkg::TAG_OBJ2;
                mul_req.a   = {2'b00, cfg.distance_weight};
                mul_req.b   = {2'b00, dist_acc_reg[47:32]};
                state_next  = ST_B0;
            end
            ST_B0:
            begin
                mul_req.tag = tdo_pkg::TAG_OBJ0;
                mul_req.a   = {2'b00, bw_eff};
                mul_req.b   = {2'b00, viol_acc_reg[15:0]};
                state_next  = ST_B1;
            end
            ST_B1:
            begin
                mul_req.tag = tdo_pkg::TAG_OBJ1;
                mul_req.a   = {2'b00, bw_eff};
                mul_req.b   = {2'b00, viol_acc_reg[31:16]};
                state_next  = ST_B2;
            end
            ST_B2:
            begin
                mul_req.tag = tdo_pkg::TAG_OBJ2;
                mul_req.a   = {2'b00, bw_eff};
                mul_req.b   = {2'b00, viol_acc_reg[47:32]};
                state_next  = ST_S0;
            end
            ST_S0:
            begin
                mul_req.tag = tdo_pkg::TAG_SPR0;
                mul_req.a   = {2'b00, cfg.spread_weight};
                mul_req.b   = {2'b00, spread_acc_reg[15:0]};
                state_next  = ST_S1;
            end
            ST_S1:
            begin
                mul_req.tag = tdo_pkg::TAG_SPR1;
                mul_req.a   = {2'b00, cfg.spread_weight};
                mul_req.b   = {10'b0, spread_acc_reg[23:16]};
                state_next  = ST_SW;
            end
            ST_SW:
            begin
                // Let the dividend settle
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                div_start  = 1'b1;
                state_next = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                // Add the rounded mean once the divider finishes
                if (div_done)
                begin
                    if (spread_apply)
                    begin
                        mag_next = mag_reg + tdo_pkg::MAG_W'(div_quot);
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // Load the result register and clear the vector on its last element
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    grad_out_next = grad_sat;
                    vv_out_next   = fin_reg;
                    obj_out_next  = fin_reg ?
                                    (tdo_pkg::OBJ_W'(0) - mag_sat[tdo_pkg::OBJ_W-1:0]) : '0;
                    if (fin_reg)
                    begin
                        dist_acc_next    = '0;
                        viol_acc_next    = '0;
                        spread_acc_next  = '0;
                        elem_count_next  = '0;
                        spread_seen_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control state and vector sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            dist_acc_reg    <= '0;
            viol_acc_reg    <= '0;
            spread_acc_reg  <= '0;
            elem_count_reg  <= '0;
            spread_seen_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            m_tvalid_reg    <= m_tvalid_next;
            dist_acc_reg    <= dist_acc_next;
            viol_acc_reg    <= viol_acc_next;
            spread_acc_reg  <= spread_acc_next;
            elem_count_reg  <= elem_count_next;
            spread_seen_reg <= spread_seen_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pred_reg     <= pred_next;
        goal_reg     <= goal_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        has_lo_reg   <= has_lo_next;
        has_hi_reg   <= has_hi_next;
        fin_reg      <= fin_next;
        g_reg        <= g_next;
        mag_reg      <= mag_next;
        num_reg      <= num_next;
        grad_out_reg <= grad_out_next;
        obj_out_reg  <= obj_out_next;
        vv_out_reg   <= vv_out_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {obj_out_reg, grad_out_reg};
    assign m_tuser[0] = vv_out_reg;

`ifndef SYNTHESIS
    // The divider only completes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DWAIT)
        else $error("divider finished outside its wait state");

    // No product is still in flight once the block is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> mul_rsp.tag == tdo_pkg::TAG_NONE)
        else $error("multiplier product pending while idle");

    // The last element of a vector leaves the sums cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_free && fin_reg) |=>
        (dist_acc_reg == '0 && viol_acc_reg == '0 && elem_count_reg == '0))
        else $error("vector sums not cleared after the last element");

    // Element count stays within the vector limit
    assert property (@(posedge clk) disable iff (!rst_n)
        elem_count_reg <= tdo_pkg::CNT_W'(tdo_pkg::MAX_ELEMENTS))
        else $error("element count past its limit");
`endif

endmodule
